// File: design/pmstk_pkg.sv
package pmstk_pkg;

  // Storage geometry
  localparam int MEM_DEPTH  = 1024;
  localparam int MAX_STACKS = 8;
  localparam int DATA_WIDTH = 32;

  // Field widths
  localparam int FUNC_W  = 2;
  localparam int SEL_W   = 3;
  localparam int CNT_W   = 11;
  localparam int NUM_W   = 4;
  localparam int STAT_W  = 2;
  localparam int ADDR_W  = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int CIDX_W  = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = CNT_W;

  // Address arithmetic width: holds base + count and MEM_DEPTH itself
  localparam int PROD_W = CNT_W + SEL_W;
  localparam int DEP_W  = $clog2(MEM_DEPTH + 1);
  localparam int SUM_W  = ((PROD_W > DEP_W) ? PROD_W : DEP_W) + 1;

  // Stream packing
  localparam int IN_DATA_W  = ((SEL_W + DATA_WIDTH + 7) / 8) * 8;
  localparam int OUT_BITS   = DATA_WIDTH + STAT_W + 2;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_PUSH = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_POP  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_PEEK = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] STAT_BAD   = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_STACKS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY   = 1'd1;

  // Reset values of the configuration registers
  localparam logic [NUM_W-1:0] NUM_STACKS_RST = 4'd3;
  localparam logic [CNT_W-1:0] CAPACITY_RST   = 11'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_EXEC,
    ST_FIN
  } state_t;

endpackage

// File: design/pmstk_ram.sv
module pmstk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write or read one entry; read data is registered and valid in the cycle after the access
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// File: design/partitioned_multi_stack.sv
// Several stacks in one shared memory, each owning a fixed region of
// stack_capacity entries starting at stack_capacity * stack number.
//
// Input stream: one request per item, in_tuser holds the operation (push,
// pop, peek) and in_tdata the stack number and the value to push. Output
// stream: one result per request with the peeked value, a status code and
// the empty and full flags of the chosen stack after the operation.
// Configuration: cfg_valid/cfg_ready write channel, index 0 sets the number
// of stacks in use, index 1 the capacity of each region. Write it only while
// no request is in flight; cfg_ready is always high.
// A request, once accepted, passes a lookup of fill count and region
// base, a memory access (single port, registered read) and a step
// that forms the flags and loads the output register. A new request is
// taken once the previous one has left for the output register.
// If the receiver stalls, the result waits in the output register; the next
// request is still accepted and computed, and holds in its final step.
// Reset clears all fill counts and loads 3 stacks of 4 entries; memory
// content is not cleared and an entry never written reads as garbage.
module partitioned_multi_stack (
  input  logic                               clk,
  input  logic                               rst_n,
  // Request stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [2:0] stack_sel, [34:3] push_value, [39:35] zero
  input  logic [pmstk_pkg::IN_DATA_W-1:0]    in_tdata,
  // [1:0] func
  input  logic [pmstk_pkg::FUNC_W-1:0]       in_tuser,
  // Result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [31:0] top_value, [33:32] status, [34] now_empty, [35] now_full, [39:36] zero
  output logic [pmstk_pkg::OUT_DATA_W-1:0]   out_tdata,
  // Configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pmstk_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pmstk_pkg::CFG_DATA_W-1:0]   cfg_data
);

  pmstk_pkg::state_t state_r, state_nxt;

  // Configuration
  logic [pmstk_pkg::NUM_W-1:0] num_stacks_r;
  logic [pmstk_pkg::CNT_W-1:0] cap_r;

  // Fill counts, one per stack
  logic [pmstk_pkg::CNT_W-1:0] counts_r [pmstk_pkg::MAX_STACKS];

  // Request in flight
  logic [pmstk_pkg::FUNC_W-1:0]     op_r;
  logic [pmstk_pkg::SEL_W-1:0]      sel_r;
  logic [pmstk_pkg::DATA_WIDTH-1:0] val_r;
  logic                             bad_r;
  logic [pmstk_pkg::SUM_W-1:0]      base_r;
  logic [pmstk_pkg::CNT_W-1:0]      cnt_r;
  logic [pmstk_pkg::CNT_W-1:0]      cnt_new_r;
  logic [pmstk_pkg::STAT_W-1:0]     stat_r;
  logic                             peek_ok_r;

  // Output register
  logic                             out_valid_r;
  logic [pmstk_pkg::DATA_WIDTH-1:0] out_top_r;
  logic [pmstk_pkg::STAT_W-1:0]     out_stat_r;
  logic                             out_empty_r;
  logic                             out_full_r;

  // Datapath signals
  logic                             in_fire;
  logic                             out_load;
  logic [pmstk_pkg::CIDX_W-1:0]     cidx;
  logic                             bad_nxt;
  logic [pmstk_pkg::SUM_W-1:0]      sum_cur;
  logic [pmstk_pkg::SUM_W-1:0]      sum_new;
  logic [pmstk_pkg::SUM_W-1:0]      peek_addr;
  logic                             full_cur;
  logic                             full_new;
  logic                             is_push;
  logic                             is_pop;
  logic                             is_peek;
  logic [pmstk_pkg::CNT_W-1:0]      cnt_new_nxt;
  logic [pmstk_pkg::STAT_W-1:0]     stat_nxt;
  logic                             peek_ok_nxt;
  logic                             ram_en;
  logic                             ram_we;
  logic [pmstk_pkg::ADDR_W-1:0]     ram_addr;
  logic [pmstk_pkg::DATA_WIDTH-1:0] ram_rdata;

  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign cidx      = pmstk_pkg::CIDX_W'(sel_r);

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_stacks_r <= pmstk_pkg::NUM_STACKS_RST;
      cap_r        <= pmstk_pkg::CAPACITY_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pmstk_pkg::CFG_NUM_STACKS: num_stacks_r <= cfg_data[pmstk_pkg::NUM_W-1:0];
        pmstk_pkg::CFG_CAPACITY:   cap_r        <= cfg_data[pmstk_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pmstk_pkg::ST_IDLE: if (in_fire) state_nxt = pmstk_pkg::ST_LOOK;
      pmstk_pkg::ST_LOOK: state_nxt = pmstk_pkg::ST_EXEC;
      pmstk_pkg::ST_EXEC: state_nxt = pmstk_pkg::ST_FIN;
      pmstk_pkg::ST_FIN:  if (!out_valid_r || out_tready) state_nxt = pmstk_pkg::ST_IDLE;
      default:            state_nxt = pmstk_pkg::ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_tready = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      pmstk_pkg::ST_IDLE: in_tready = 1'b1;
      pmstk_pkg::ST_FIN:  out_load  = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pmstk_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r  <= in_tuser;
      sel_r <= in_tdata[pmstk_pkg::SEL_W-1:0];
      val_r <= in_tdata[pmstk_pkg::SEL_W +: pmstk_pkg::DATA_WIDTH];
    end
  end

  // Look up count and region base
  assign bad_nxt = ({1'b0, sel_r} >= num_stacks_r) ||
                   (pmstk_pkg::SUM_W'(sel_r) >= pmstk_pkg::SUM_W'(pmstk_pkg::MAX_STACKS));

  always_ff @(posedge clk) begin
    if (state_r == pmstk_pkg::ST_LOOK) begin
      bad_r  <= bad_nxt;
      cnt_r  <= bad_nxt ? '0 : counts_r[cidx];
      base_r <= pmstk_pkg::SUM_W'(cap_r) * pmstk_pkg::SUM_W'(sel_r);
    end
  end

  // Decide the operation against the current count
  assign is_push   = (op_r == pmstk_pkg::FUNC_PUSH);
  assign is_pop    = (op_r == pmstk_pkg::FUNC_POP);
  assign is_peek   = (op_r == pmstk_pkg::FUNC_PEEK);
  assign sum_cur   = base_r + pmstk_pkg::SUM_W'(cnt_r);
  assign peek_addr = sum_cur - pmstk_pkg::SUM_W'(1);
  assign full_cur  = (cnt_r >= cap_r) ||
                     (sum_cur >= pmstk_pkg::SUM_W'(pmstk_pkg::MEM_DEPTH));

  always_comb begin
    cnt_new_nxt = cnt_r;
    stat_nxt    = pmstk_pkg::STAT_OK;
    peek_ok_nxt = 1'b0;
    if (bad_r) begin
      stat_nxt = pmstk_pkg::STAT_BAD;
    end else if (is_push) begin
      if (full_cur) begin
        stat_nxt = pmstk_pkg::STAT_FULL;
      end else begin
        cnt_new_nxt = cnt_r + pmstk_pkg::CNT_W'(1);
      end
    end else if (is_pop || is_peek) begin
      if (cnt_r == '0) begin
        stat_nxt = pmstk_pkg::STAT_EMPTY;
      end else if (is_pop) begin
        cnt_new_nxt = cnt_r - pmstk_pkg::CNT_W'(1);
      end else begin
        peek_ok_nxt = (peek_addr < pmstk_pkg::SUM_W'(pmstk_pkg::MEM_DEPTH));
      end
    end
  end

  // Memory access: write on push, read on peek
  assign ram_we   = (state_r == pmstk_pkg::ST_EXEC) && !bad_r && is_push && !full_cur;
  assign ram_en   = ram_we || ((state_r == pmstk_pkg::ST_EXEC) && peek_ok_nxt);
  assign ram_addr = is_push ? sum_cur[pmstk_pkg::ADDR_W-1:0]
                            : peek_addr[pmstk_pkg::ADDR_W-1:0];

  pmstk_ram #(
    .WIDTH (pmstk_pkg::DATA_WIDTH),
    .DEPTH (pmstk_pkg::MEM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (val_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (state_r == pmstk_pkg::ST_EXEC) begin
      cnt_new_r <= cnt_new_nxt;
      stat_r    <= stat_nxt;
      peek_ok_r <= peek_ok_nxt;
    end
  end

  // Write back the fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < pmstk_pkg::MAX_STACKS; i++) begin
        counts_r[i] <= '0;
      end
    end else if ((state_r == pmstk_pkg::ST_EXEC) && !bad_r) begin
      counts_r[cidx] <= cnt_new_nxt;
    end
  end

  // Flags after the operation
  assign sum_new  = base_r + pmstk_pkg::SUM_W'(cnt_new_r);
  assign full_new = (cnt_new_r >= cap_r) ||
                    (sum_new >= pmstk_pkg::SUM_W'(pmstk_pkg::MEM_DEPTH));

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_top_r   <= peek_ok_r ? ram_rdata : '0;
      out_stat_r  <= stat_r;
      out_empty_r <= !bad_r && (cnt_new_r == '0);
      out_full_r  <= !bad_r && full_new;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(pmstk_pkg::OUT_DATA_W - pmstk_pkg::OUT_BITS){1'b0}},
                       out_full_r, out_empty_r, out_stat_r, out_top_r};

  // Checks
  a_accept_to_look: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == pmstk_pkg::ST_LOOK)
    else $error("accepted request did not enter lookup");

  a_write_only_push: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (op_r == pmstk_pkg::FUNC_PUSH) && !bad_r && (cnt_r < cap_r))
    else $error("memory written outside a legal push");

  a_push_counts_up: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pmstk_pkg::ST_FIN) && is_push && (stat_r == pmstk_pkg::STAT_OK) && !bad_r
    |-> cnt_new_r == cnt_r + pmstk_pkg::CNT_W'(1))
    else $error("push did not advance the fill count");

  a_bad_no_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && bad_r |=> (out_stat_r == pmstk_pkg::STAT_BAD) && !out_empty_r && !out_full_r)
    else $error("bad stack result carries flags");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pmstk_pkg::ST_EXEC) |-> !in_tready)
    else $error("request accepted while one is in flight");

endmodule
